### rtl/assert_macros.svh
// Assertion macros used by the RTL of the duplicate filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed: invariant");

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/fdf_pkg.sv
// Package for the flood duplicate filter: sizes, register indexes, action codes.
`default_nettype none
package fdf_pkg;

  // History storage
  localparam int HistDepth = 16;
  localparam int IdWidth   = 32;
  localparam int IdxW      = (HistDepth > 1) ? $clog2(HistDepth) : 1;
  localparam int CntW      = $clog2(HistDepth + 1);
  localparam int WideW     = CntW + 1;

  // Field widths fixed by the interface
  localparam int MsgIdW    = 32;
  localparam int HopW      = 9;
  localparam int OutHopW   = 8;
  localparam int RandW     = 16;
  localparam int LimitW    = 5;
  localparam int ProbW     = 17;
  localparam int ActW      = 3;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 17;

  // Reset values of the configuration registers
  localparam logic [LimitW-1:0] LimitReset = LimitW'(16);
  localparam logic [ProbW-1:0]  ProbReset  = ProbW'(65536);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegHistoryLimit = 1'b0,
    RegForwardProb  = 1'b1
  } cfg_reg_e;

  // Result action codes
  typedef enum logic [ActW-1:0] {
    ActRejected   = 3'd0,
    ActOriginated = 3'd1,
    ActDuplicate  = 3'd2,
    ActTtlZero    = 3'd3,
    ActDeclined   = 3'd4,
    ActForwarded  = 3'd5
  } action_e;

endpackage
`default_nettype wire

### rtl/flood_duplicate_filter_core.sv
// Flood duplicate filter: FIFO id history, duplicate drop and forward decision.
//
// Usage: drive one message event on req_type_i, message_id_i, hop_count_i and
// random_value_i with start_i high; the event transfers at a rising edge with
// start_i high and busy_o low. busy_o stays low, so an event can be sent in
// every cycle. The result (action_o, out_hops_o) appears in the cycle after the
// transfer, marked by done_o for exactly one cycle; the receiver cannot stall.
// Throughput 1 event per cycle: the 16 id compares run in parallel against
// the history registers, and the history update of one event is written at
// the same edge, so the next event sees it.
// Configuration: cfg_we_i with cfg_idx_i (0 history limit, 1 forward
// probability) and cfg_wdata_i writes a register at the clock edge; write it
// only while no event is in flight.
// Reset (rst_ni low, asynchronous) empties the history, sets the history limit
// to 16 and the forward probability to 65536 (always forward), and clears
// done_o.
`default_nettype none
`include "assert_macros.svh"

module flood_duplicate_filter_core
  import fdf_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // Event channel
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire logic                       req_type_i,
  input  wire logic        [MsgIdW-1:0]   message_id_i,
  input  wire logic signed [HopW-1:0]     hop_count_i,
  input  wire logic        [RandW-1:0]    random_value_i,
  // Result channel
  output logic                            done_o,
  output logic             [ActW-1:0]     action_o,
  output logic             [OutHopW-1:0]  out_hops_o,
  // Configuration port
  input  wire logic                       cfg_we_i,
  input  wire logic        [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic        [CfgDataW-1:0] cfg_wdata_i
);

  // State
  logic [IdWidth-1:0] store_q [HistDepth];
  logic [CntW-1:0]    fill_q, fill_d;
  logic [IdxW-1:0]    oldest_q, oldest_d;
  logic [LimitW-1:0]  limit_q;
  logic [ProbW-1:0]   prob_q;
  logic               done_q;
  action_e            action_q, action_d;
  logic [OutHopW-1:0] hops_q, hops_d;

  logic [IdWidth-1:0] id;
  logic [HistDepth-1:0] hit_vec;
  logic               seen;
  logic               accept;
  logic               record;
  logic [CntW-1:0]    lim;
  logic [CntW-1:0]    drop;
  logic [CntW-1:0]    base_fill;
  logic [IdxW-1:0]    base_oldest;
  logic [IdxW-1:0]    wr_slot;
  logic [WideW-1:0]   sum_old;
  logic [WideW-1:0]   sum_wr;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign id     = IdWidth'(message_id_i);

  // Parallel compare against every live history entry
  always_comb begin
    logic [WideW-1:0] off;
    for (int s = 0; s < HistDepth; s++) begin
      if (WideW'(s) >= WideW'(oldest_q)) begin
        off = WideW'(s) - WideW'(oldest_q);
      end else begin
        off = WideW'(s) + WideW'(HistDepth) - WideW'(oldest_q);
      end
      hit_vec[s] = (off < WideW'(fill_q)) && (store_q[s] == id);
    end
  end
  assign seen = |hit_vec;

  // Effective limit, clamped to the storage depth
  always_comb begin
    if (32'(limit_q) > 32'(HistDepth)) begin
      lim = CntW'(HistDepth);
    end else begin
      lim = CntW'(limit_q);
    end
  end

  // Decision
  always_comb begin
    record   = 1'b0;
    action_d = ActRejected;
    hops_d   = '0;
    if (req_type_i) begin
      if (hop_count_i[HopW-1]) begin
        action_d = ActRejected;
      end else begin
        record   = 1'b1;
        action_d = ActOriginated;
        hops_d   = hop_count_i[OutHopW-1:0];
      end
    end else if (seen) begin
      action_d = ActDuplicate;
    end else begin
      record = 1'b1;
      if (hop_count_i == '0) begin
        action_d = ActTtlZero;
      end else if ({1'b0, random_value_i} <= prob_q) begin
        action_d = ActForwarded;
        hops_d   = hop_count_i[HopW-1] ? '0 : hop_count_i[OutHopW-1:0];
      end else begin
        action_d = ActDeclined;
      end
    end
  end

  // History update: evict down to limit - 1 when full, then append
  always_comb begin
    if (fill_q >= lim) begin
      drop      = fill_q - lim + CntW'(1);
      base_fill = lim - CntW'(1);
    end else begin
      drop      = '0;
      base_fill = fill_q;
    end
    sum_old = WideW'(oldest_q) + WideW'(drop);
    if (sum_old >= WideW'(HistDepth)) begin
      sum_old = sum_old - WideW'(HistDepth);
    end
    base_oldest = sum_old[IdxW-1:0];
    sum_wr = WideW'(base_oldest) + WideW'(base_fill);
    if (sum_wr >= WideW'(HistDepth)) begin
      sum_wr = sum_wr - WideW'(HistDepth);
    end
    wr_slot = sum_wr[IdxW-1:0];

    fill_d   = fill_q;
    oldest_d = oldest_q;
    if (accept && record && (lim != '0)) begin
      fill_d   = base_fill + CntW'(1);
      oldest_d = base_oldest;
    end
  end

  // History control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      oldest_q <= '0;
      limit_q  <= LimitReset;
      prob_q   <= ProbReset;
      done_q   <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      oldest_q <= oldest_d;
      done_q   <= accept;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          RegHistoryLimit: limit_q <= cfg_wdata_i[LimitW-1:0];
          RegForwardProb:  prob_q  <= cfg_wdata_i[ProbW-1:0];
          default: ;
        endcase
      end
    end
  end

  // History ids
  always_ff @(posedge clk_i) begin
    if (accept && record && (lim != '0)) begin
      store_q[wr_slot] <= id;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_d;
      hops_q   <= hops_d;
    end
  end

  assign done_o     = done_q;
  assign action_o   = action_q;
  assign out_hops_o = hops_q;

  // Checks
  `ASSERT_ALWAYS(a_fill_bound, fill_q <= CntW'(HistDepth))
  `ASSERT_NEXT(a_result_follows, start_i && !busy_o, done_o)
  `ASSERT_NEXT(a_no_spurious_result, !start_i, !done_o)
  `ASSERT_IMPLIES(a_dup_needs_history, done_o && (action_q == ActDuplicate),
                  ($past(fill_q) != '0) && (out_hops_o == '0))

endmodule
`default_nettype wire

### tb/flood_duplicate_filter_core_tb.sv
// Self-checking testbench for the flood duplicate filter: directed and random message events.
`default_nettype none

module flood_duplicate_filter_core_tb;
  import fdf_pkg::*;

  localparam int StallLimit   = 2000;
  localparam int MaxReports   = 10;
  localparam int RecentN      = 24;
  localparam int RandomPhases = 10;
  localparam int PhaseItems   = 123;

  typedef struct packed {
    action_e              action;
    logic [OutHopW-1:0]   hops;
  } filter_result_t;

  // DUT ports
  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start_i = 1'b0;
  logic                       busy_o;
  logic                       req_type_i = 1'b0;
  logic        [MsgIdW-1:0]   message_id_i = '0;
  logic signed [HopW-1:0]     hop_count_i = '0;
  logic        [RandW-1:0]    random_value_i = '0;
  logic                       done_o;
  logic        [ActW-1:0]     action_o;
  logic        [OutHopW-1:0]  out_hops_o;
  logic                       cfg_we_i = 1'b0;
  logic        [CfgIdxW-1:0]  cfg_idx_i = RegHistoryLimit;
  logic        [CfgDataW-1:0] cfg_wdata_i = '0;

  // Mirror of the id history and the registers
  logic [MsgIdW-1:0] hist_ids [HistDepth];
  int                hist_fill;
  int                hist_head;
  logic [LimitW-1:0] hist_limit;
  logic [ProbW-1:0]  fwd_prob;

  // Expected results, oldest first
  filter_result_t pending_actions[$];
  filter_result_t head_result;

  // Ids already sent, reused to provoke duplicates
  logic [MsgIdW-1:0] recent_ids [RecentN];
  int                recent_wr;
  int                recent_cnt;

  int idle_pct = 18;
  int fail_count;
  int events_sent;
  int directed_events;
  int cfg_writes;
  int stall_cycles;
  int action_seen [6];

  flood_duplicate_filter_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_type_i     (req_type_i),
    .message_id_i   (message_id_i),
    .hop_count_i    (hop_count_i),
    .random_value_i (random_value_i),
    .done_o         (done_o),
    .action_o       (action_o),
    .out_hops_o     (out_hops_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= MaxReports) $display("ERROR at %0t: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // History mirror
  // ---------------------------------------------------------------------------
  function automatic bit id_in_history(input logic [MsgIdW-1:0] id);
    for (int k = 0; k < hist_fill; k++) begin
      if (hist_ids[(hist_head + k) % HistDepth] == id) return 1'b1;
    end
    return 1'b0;
  endfunction

  // FIFO append; a lowered limit drops the oldest entries at the next append
  function automatic void remember_id(input logic [MsgIdW-1:0] id);
    int lim;
    lim = (int'(hist_limit) > HistDepth) ? HistDepth : int'(hist_limit);
    if (lim == 0) return;
    if (hist_fill >= lim) begin
      hist_head = (hist_head + hist_fill - lim + 1) % HistDepth;
      hist_fill = lim - 1;
    end
    hist_ids[(hist_head + hist_fill) % HistDepth] = id;
    hist_fill++;
  endfunction

  // Outcome of one message event; updates the history mirror
  function automatic filter_result_t filter_decision(input logic kind,
                                                     input logic [MsgIdW-1:0] id,
                                                     input logic signed [HopW-1:0] hops,
                                                     input logic [RandW-1:0] rnd);
    filter_result_t r;
    r.action = ActRejected;
    r.hops   = '0;
    if (kind) begin
      if (hops >= 0) begin
        remember_id(id);
        r.action = ActOriginated;
        r.hops   = hops[OutHopW-1:0];
      end
    end else if (id_in_history(id)) begin
      r.action = ActDuplicate;
    end else begin
      remember_id(id);
      if (hops == 0) begin
        r.action = ActTtlZero;
      end else if ({1'b0, rnd} <= fwd_prob) begin
        r.action = ActForwarded;
        r.hops   = (hops < 0) ? '0 : hops[OutHopW-1:0];
      end else begin
        r.action = ActDeclined;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Start stays high after a transfer so back-to-back events need no toggle
  task automatic send_event(input logic kind, input logic [MsgIdW-1:0] id,
                            input logic signed [HopW-1:0] hops,
                            input logic [RandW-1:0] rnd);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i        <= 1'b1;
    req_type_i     <= kind;
    message_id_i   <= id;
    hop_count_i    <= hops;
    random_value_i <= rnd;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_actions = {pending_actions, filter_decision(kind, id, hops, rnd)};
    events_sent++;
    recent_ids[recent_wr] = id;
    recent_wr = (recent_wr + 1) % RecentN;
    if (recent_cnt < RecentN) recent_cnt++;
  endtask

  // Stop sending and wait until every expected result has been seen
  task automatic drain_results();
    start_i <= 1'b0;
    while (pending_actions.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Write both registers on consecutive edges; block must be idle
  task automatic write_config(input logic [LimitW-1:0] limit, input logic [ProbW-1:0] prob);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= RegHistoryLimit;
    cfg_wdata_i <= CfgDataW'(limit);
    @(posedge clk_i);
    hist_limit = limit;
    cfg_idx_i   <= RegForwardProb;
    cfg_wdata_i <= CfgDataW'(prob);
    @(posedge clk_i);
    fwd_prob = prob;
    cfg_we_i <= 1'b0;
    cfg_writes += 2;
  endtask

  // Mostly receives, many of them repeats of recent ids
  task automatic send_random_event();
    logic                   kind;
    logic [MsgIdW-1:0]      id;
    logic signed [HopW-1:0] hops;
    logic [RandW-1:0]       rnd;
    int                     sel;
    int                     near;
    kind = ($urandom_range(99) < 22);
    if (recent_cnt > 0 && $urandom_range(99) < 55)
      id = recent_ids[(recent_wr + RecentN - 1 - $urandom_range(recent_cnt - 1)) % RecentN];
    else
      id = $urandom;
    sel = $urandom_range(99);
    if (sel < 20)      hops = '0;
    else if (sel < 35) hops = -9'($urandom_range(128, 1));
    else               hops = 9'($urandom_range(255, 1));
    if ($urandom_range(99) < 35) begin
      near = int'(fwd_prob) + int'($urandom_range(2)) - 1;
      if (near < 0) near = 0;
      if (near > 65535) near = 65535 - int'($urandom_range(1));
      rnd = RandW'(near);
    end else begin
      rnd = RandW'($urandom_range(65535));
    end
    send_event(kind, id, hops, rnd);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && done_o !== 1'b0) begin
      if (int'(action_o) < 6) action_seen[action_o]++;
      if (pending_actions.size() == 0) begin
        note_failure($sformatf("result with nothing expected: action %0d hops %0d",
                               action_o, out_hops_o));
      end else begin
        head_result = pending_actions[0];
        pending_actions.delete(0);
        if (action_o !== head_result.action)
          note_failure($sformatf("action expected %0d got %0d",
                                 head_result.action, action_o));
        if (out_hops_o !== head_result.hops)
          note_failure($sformatf("out_hops expected %0d got %0d (action %0d)",
                                 head_result.hops, out_hops_o, head_result.action));
      end
    end
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("timeout: no transfer for %0d cycles", StallLimit);
      $display("flood_duplicate_filter_core_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Originations, rejections, ttl zero, duplicates, probability edges
  task automatic test_origination_and_receive();
    send_event(1'b1, 32'h0000_0000, 9'sd0, 16'h0000);
    send_event(1'b1, 32'hFFFF_FFFF, 9'sd255, 16'hFFFF);
    send_event(1'b1, 32'h0000_1234, -9'sd1, 16'h0000);
    send_event(1'b1, 32'h0000_5678, -9'sd128, 16'h0000);
    send_event(1'b0, 32'hFFFF_FFFF, 9'sd3, 16'h0000);      // seen at origination
    send_event(1'b0, 32'h0000_1234, 9'sd0, 16'h0000);      // rejected id not kept
    send_event(1'b0, 32'h0000_1234, 9'sd7, 16'h0000);      // now a duplicate
    send_event(1'b0, 32'hA5A5_0001, -9'sd128, 16'hFFFF);   // negative ttl forwards with 0
    send_event(1'b0, 32'hA5A5_0002, 9'sd255, 16'hFFFF);
    send_event(1'b1, 32'hA5A5_0002, 9'sd1, 16'h0000);      // no history check on send
    drain_results();
    write_config(LimitW'(16), ProbW'(0));
    send_event(1'b0, 32'h5A5A_0001, 9'sd9, 16'h0000);
    send_event(1'b0, 32'h5A5A_0002, 9'sd9, 16'h0001);
    send_event(1'b0, 32'h5A5A_0003, 9'sd9, 16'hFFFF);
    drain_results();
    write_config(LimitW'(16), ProbW'(65535));
    send_event(1'b0, 32'h5A5A_0004, 9'sd4, 16'hFFFF);
  endtask

  // Small window, lowered limit, limit zero, limit above depth
  task automatic test_history_window();
    drain_results();
    write_config(LimitW'(3), ProbW'(65536));
    send_event(1'b0, 32'hC0DE_000A, 9'sd1, 16'h1111);
    send_event(1'b0, 32'hC0DE_000B, 9'sd1, 16'h2222);
    send_event(1'b0, 32'hC0DE_000C, 9'sd1, 16'h3333);
    send_event(1'b0, 32'hC0DE_000D, 9'sd1, 16'h4444);
    send_event(1'b0, 32'hC0DE_000A, 9'sd2, 16'h5555);      // evicted, fresh again
    send_event(1'b0, 32'hC0DE_000D, 9'sd2, 16'h6666);
    drain_results();
    write_config(LimitW'(0), ProbW'(65536));
    send_event(1'b0, 32'hC0DE_000E, 9'sd5, 16'h0000);
    send_event(1'b0, 32'hC0DE_000E, 9'sd5, 16'h0000);      // not recorded
    send_event(1'b0, 32'hC0DE_000C, 9'sd5, 16'h0000);      // held entry still found
    drain_results();
    write_config(LimitW'(31), ProbW'(32768));
    send_event(1'b0, 32'h7777_0001, 9'sd6, 16'h8000);
    send_event(1'b0, 32'h7777_0002, 9'sd6, 16'h8001);
    drain_results();
  endtask

  // Phases of random traffic, each under its own register setting
  task automatic test_random_traffic();
    logic [LimitW-1:0] limit;
    logic [ProbW-1:0]  prob;
    for (int phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0: begin limit = LimitW'(16); prob = ProbW'(65536); end
        1: begin limit = LimitW'(1);  prob = ProbW'(0);     end
        2: begin limit = LimitW'(0);  prob = ProbW'(65535); end
        3: begin limit = LimitW'(16); prob = ProbW'(32768); end
        4: begin limit = LimitW'(31); prob = ProbW'(1);     end
        5: begin limit = LimitW'(2);  prob = ProbW'(65536); end
        6: begin limit = LimitW'(8);  prob = ProbW'(49152); end
        default: begin
          limit = LimitW'($urandom_range(16));
          prob  = ProbW'($urandom_range(65536));
        end
      endcase
      idle_pct = (phase == 3) ? 0 : 18;   // one long back-to-back stretch
      drain_results();
      write_config(limit, prob);
      repeat (PhaseItems) send_random_event();
    end
    drain_results();
    idle_pct = 18;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    hist_fill  = 0;
    hist_head  = 0;
    hist_limit = LimitReset;
    fwd_prob   = ProbReset;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_origination_and_receive();
    test_history_window();
    directed_events = events_sent;
    test_random_traffic();

    drain_results();
    repeat (4) @(posedge clk_i);
    if (pending_actions.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_actions.size()));

    $display("Covered %0d message events (%0d directed), %0d register writes, %0d phases.",
             events_sent, directed_events, cfg_writes, RandomPhases);
    $display("Actions: rejected %0d originated %0d duplicate %0d ttl0 %0d declined %0d fwd %0d",
             action_seen[0], action_seen[1], action_seen[2], action_seen[3],
             action_seen[4], action_seen[5]);
    if (fail_count == 0) begin
      $display("flood_duplicate_filter_core_tb OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("flood_duplicate_filter_core_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
